>>> src/sum_checksum_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame parser checker
// These macros give shorthand for clocked concurrent assertions with an error report.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKSUM_FRAME_PARSER_UNIT_ASSERT_SVH
`define SUM_CHECKSUM_FRAME_PARSER_UNIT_ASSERT_SVH

// This assertion is checked outside reset only.
`define SCFP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame parser assertion failed");

// This assertion is checked at every edge, reset included.
`define SCFP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("frame parser assertion failed");

`endif

>>> src/scfp_pkg.sv
// ----------------------------------------------------------------------------
// Frame parser package
// This package holds the byte constants shared by the parser and its checker.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h2E;
  localparam logic [BYTE_W-1:0] ACK_VALUE  = 8'hFF;

endpackage

>>> src/sum_checksum_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Sum checksum frame parser
// Latency: a result appears in the cycle after a checksum byte that matches is accepted.
// Throughput: one byte per cycle while the byte input does not stall.
// The byte input stalls only while a result waits and out_ready is low.
// Synchronous reset returns the parser to waiting for the start byte and
// empties the result register.
// ----------------------------------------------------------------------------
module sum_checksum_frame_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [scfp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic [scfp_pkg::BYTE_W-1:0]   ack_byte,
  output logic [scfp_pkg::BYTE_W-1:0]   packet_command,
  output logic [scfp_pkg::BYTE_W-1:0]   packet_length,
  output logic                          out_valid,
  input  logic                          out_ready
);

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CSUM = 3'd4
  } phase_t;

  phase_t                        phase, phase_next;
  logic [scfp_pkg::BYTE_W-1:0]   held_command, held_command_next;
  logic [scfp_pkg::BYTE_W-1:0]   held_length, held_length_next;
  logic [scfp_pkg::BYTE_W-1:0]   bytes_left, bytes_left_next;
  logic [scfp_pkg::BYTE_W-1:0]   running_sum, running_sum_next;
  logic                          csum_ok;
  logic                          accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign ack_byte = scfp_pkg::ACK_VALUE;

  always_comb begin
    phase_next        = phase;
    held_command_next = held_command;
    held_length_next  = held_length;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    csum_ok           = 1'b0;
    unique case (phase)
      PH_WAIT: begin
        if (rx_byte == scfp_pkg::START_BYTE) begin
          phase_next = PH_CMD;
        end
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        running_sum_next  = rx_byte;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        held_length_next = rx_byte;
        bytes_left_next  = rx_byte;
        running_sum_next = running_sum + rx_byte;
        phase_next       = (rx_byte != '0) ? PH_DATA : PH_CSUM;
      end
      PH_DATA: begin
        running_sum_next = running_sum + rx_byte;
        bytes_left_next  = bytes_left - 1'b1;
        if (bytes_left_next == '0) begin
          phase_next = PH_CSUM;
        end
      end
      PH_CSUM: begin
        csum_ok    = (rx_byte == ~running_sum);
        phase_next = PH_WAIT;
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      held_command <= '0;
      held_length  <= '0;
      bytes_left   <= '0;
      running_sum  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        held_command <= held_command_next;
        held_length  <= held_length_next;
        bytes_left   <= bytes_left_next;
        running_sum  <= running_sum_next;
      end
      if (accept && csum_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && csum_ok) begin
      packet_command <= held_command;
      packet_length  <= held_length;
    end
  end

endmodule

>>> src/scfp_checker.sv
// ----------------------------------------------------------------------------
// Frame parser port checker
// This checker watches the parser ports for result and flow-control slips.
// ----------------------------------------------------------------------------
`include "sum_checksum_frame_parser_unit_assert.svh"

module scfp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic [scfp_pkg::BYTE_W-1:0]   rx_byte,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [scfp_pkg::BYTE_W-1:0]   ack_byte,
  input logic [scfp_pkg::BYTE_W-1:0]   packet_command,
  input logic [scfp_pkg::BYTE_W-1:0]   packet_length,
  input logic                          out_valid,
  input logic                          out_ready
);

  logic byte_seen;

  assign byte_seen = in_valid && in_ready && (rx_byte == rx_byte);

  `SCFP_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid)
  `SCFP_ASSERT(a_ack_value, out_valid |-> ack_byte == scfp_pkg::ACK_VALUE)
  `SCFP_ASSERT(a_result_from_byte, $rose(out_valid) |-> $past(byte_seen))
  `SCFP_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(packet_command) && $stable(packet_length))
  `SCFP_ASSERT(a_backpressure, out_valid && !out_ready |-> !in_ready)

endmodule

bind sum_checksum_frame_parser_unit scfp_checker u_scfp_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_byte        (rx_byte),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .ack_byte       (ack_byte),
  .packet_command (packet_command),
  .packet_length  (packet_length),
  .out_valid      (out_valid),
  .out_ready      (out_ready)
);

>>> test/tb_sum_checksum_frame_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sum checksum frame parser
// A byte stream of directed frames, then random frames, noise, bad checksums
// and cut-off frames, is sent with random gaps while the result side stalls
// at random. A behavioural parser predicts each acknowledge, and every result
// is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sum_checksum_frame_parser_unit;

  typedef enum logic [2:0] {
    WAIT_START,
    TAKE_COMMAND,
    TAKE_LENGTH,
    TAKE_PAYLOAD,
    TAKE_CHECKSUM
  } phase_t;

  typedef struct packed {
    logic [scfp_pkg::BYTE_W-1:0] ack;
    logic [scfp_pkg::BYTE_W-1:0] command;
    logic [scfp_pkg::BYTE_W-1:0] length;
  } ack_t;

  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 4;
  localparam int RANDOM_BYTES = 860;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic [scfp_pkg::BYTE_W-1:0] rx_byte   = '0;
  logic                        in_valid  = 1'b0;
  logic                        out_ready = 1'b0;
  logic                        in_ready;
  logic [scfp_pkg::BYTE_W-1:0] ack_byte;
  logic [scfp_pkg::BYTE_W-1:0] packet_command;
  logic [scfp_pkg::BYTE_W-1:0] packet_length;
  logic                        out_valid;

  logic [scfp_pkg::BYTE_W-1:0] rx_stream[$];
  ack_t                        acks_due[$];

  phase_t                      phase;
  logic [scfp_pkg::BYTE_W-1:0] frame_command;
  logic [scfp_pkg::BYTE_W-1:0] frame_length;
  logic [scfp_pkg::BYTE_W-1:0] remaining;
  logic [scfp_pkg::BYTE_W-1:0] frame_sum;

  int bytes_queued   = 0;
  int bytes_sent     = 0;
  int frames_built   = 0;
  int acks_checked   = 0;
  int mismatch_count = 0;
  int send_gap       = 0;
  int send_burst     = 0;
  int recv_gap       = 0;
  int recv_burst     = 0;

  sum_checksum_frame_parser_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .ack_byte       (ack_byte),
    .packet_command (packet_command),
    .packet_length  (packet_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int pick_gap(inout int burst);
    int roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic reset_parser();
    phase         = WAIT_START;
    frame_command = '0;
    frame_length  = '0;
    remaining     = '0;
    frame_sum     = '0;
  endtask

  task automatic predict_byte(input logic [scfp_pkg::BYTE_W-1:0] b);
    case (phase)
      WAIT_START: begin
        if (b == scfp_pkg::START_BYTE) phase = TAKE_COMMAND;
      end
      TAKE_COMMAND: begin
        frame_command = b;
        frame_sum     = b;
        phase         = TAKE_LENGTH;
      end
      TAKE_LENGTH: begin
        frame_length = b;
        remaining    = b;
        frame_sum    = frame_sum + b;
        phase        = (b != '0) ? TAKE_PAYLOAD : TAKE_CHECKSUM;
      end
      TAKE_PAYLOAD: begin
        frame_sum = frame_sum + b;
        remaining = remaining - 1'b1;
        if (remaining == '0) phase = TAKE_CHECKSUM;
      end
      TAKE_CHECKSUM: begin
        if (b == ~frame_sum) begin
          acks_due.push_back('{scfp_pkg::ACK_VALUE, frame_command, frame_length});
        end
        phase = WAIT_START;
      end
      default: begin
        phase = WAIT_START;
      end
    endcase
  endtask

  task automatic add_frame(input logic [scfp_pkg::BYTE_W-1:0] command, input int len,
                           input bit good_sum, input bit use_fill = 1'b0,
                           input logic [scfp_pkg::BYTE_W-1:0] fill = '0);
    logic [scfp_pkg::BYTE_W-1:0] sum;
    logic [scfp_pkg::BYTE_W-1:0] data;
    rx_stream.push_back(scfp_pkg::START_BYTE);
    rx_stream.push_back(command);
    rx_stream.push_back(len[scfp_pkg::BYTE_W-1:0]);
    sum = command + len[scfp_pkg::BYTE_W-1:0];
    for (int i = 0; i < len; i++) begin
      if (use_fill) data = fill;
      else if ($urandom_range(0, 15) == 0) data = scfp_pkg::START_BYTE;
      else data = 8'($urandom_range(0, 255));
      rx_stream.push_back(data);
      sum = sum + data;
    end
    sum = ~sum;
    if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
    rx_stream.push_back(sum);
    frames_built++;
  endtask

  always @(posedge clk) begin : driver
    logic                        next_valid;
    logic [scfp_pkg::BYTE_W-1:0] next_byte;
    if (rst) begin
      reset_parser();
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_byte  = rx_byte;
      if (in_valid && in_ready) begin
        predict_byte(rx_byte);
        bytes_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (rx_stream.size() > 0) begin
          next_valid = 1'b1;
          next_byte  = rx_stream.pop_front();
          send_gap   = pick_gap(send_burst);
        end
      end
      in_valid <= next_valid;
      rx_byte  <= next_byte;
    end
  end

  always @(posedge clk) begin : monitor
    ack_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (acks_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result: ack %h command %h length %h",
                                    ack_byte, packet_command, packet_length));
        end else begin
          want = acks_due.pop_front();
          acks_checked++;
          if (ack_byte !== want.ack)
            report_mismatch($sformatf("ack_byte got %h expected %h", ack_byte, want.ack));
          if (packet_command !== want.command)
            report_mismatch($sformatf("packet_command got %h expected %h",
                                      packet_command, want.command));
          if (packet_length !== want.length)
            report_mismatch($sformatf("packet_length got %h expected %h",
                                      packet_length, want.length));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap(recv_burst);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Stalled with %0d requests queued and %0d results outstanding.",
             rx_stream.size(), acks_due.size());
    $display("sum_checksum_frame_parser_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    int target;
    int roll;
    int len;
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'h2D);
    rx_stream.push_back(8'h2F);
    add_frame(8'h00, 0, 1'b1);
    add_frame(8'hFF, 1, 1'b1, 1'b1, scfp_pkg::START_BYTE);
    add_frame(scfp_pkg::START_BYTE, 0, 1'b1);
    add_frame(8'h05, 0, 1'b0);
    add_frame(8'hD1, 0, 1'b1);
    add_frame(8'h10, int'(scfp_pkg::START_BYTE), 1'b1);
    add_frame(8'($urandom_range(0, 255)), 255, 1'b1);

    target = rx_stream.size() + RANDOM_BYTES;
    while (rx_stream.size() < target) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 40);
      else len = $urandom_range(0, 8);
      if (roll < 75) begin
        add_frame(8'($urandom_range(0, 255)), len, 1'b1);
      end else if (roll < 85) begin
        add_frame(8'($urandom_range(0, 255)), len, 1'b0);
      end else if (roll < 92) begin
        repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(2, 6);
        rx_stream.push_back(scfp_pkg::START_BYTE);
        rx_stream.push_back(8'($urandom_range(0, 255)));
        rx_stream.push_back(len[scfp_pkg::BYTE_W-1:0]);
        repeat ($urandom_range(0, len - 1)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end
    end
    bytes_queued = rx_stream.size();

    @(negedge clk);
    while (rst || bytes_sent < bytes_queued || acks_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d bytes holding %0d built frames plus noise and cut-off frames.",
             bytes_sent, frames_built);
    $display("Checked %0d acknowledges; %0d mismatches found.", acks_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sum_checksum_frame_parser_unit: match");
    end else begin
      $display("sum_checksum_frame_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
